// ----- rtl/sensor_frame_checksum_parser_macros.svh -----
// Assertion helpers for the frame parser checkers.
// Both expect i_clk and i_rst_n in the scope where they are used.
`ifndef SENSOR_FRAME_CHECKSUM_PARSER_MACROS_SVH
`define SENSOR_FRAME_CHECKSUM_PARSER_MACROS_SVH

// Same-cycle implication.
`define SFCP_CHK_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SFCP_CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sfcp_pkg.sv -----
`default_nettype none

package sfcp_pkg;

    localparam int FRAME_LEN  = 32;
    localparam int SUM_LEN    = 30;
    localparam int WORD_COUNT = 12;
    localparam int ADDR_W     = $clog2(FRAME_LEN);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int IDX_W      = 4;
    // 30 bytes of 255 stay below 2^13
    localparam int SUM_W      = 13;

    localparam logic [7:0] START1 = 8'h42;
    localparam logic [7:0] START2 = 8'h4D;

    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_TIMEOUT = 1'b1;

    localparam logic [ADDR_W-1:0] WORD_BASE_ADDR = ADDR_W'(4);
    localparam logic [ADDR_W-1:0] CHK_HI_ADDR    = ADDR_W'(30);
    localparam logic [ADDR_W-1:0] CHK_LO_ADDR    = ADDR_W'(31);

    typedef enum logic [2:0] {
        ST_SEEK,
        ST_FILL,
        ST_SUM,
        ST_HI,
        ST_LO,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              sum_clr;
        logic              sum_acc;
        logic              cap_hi;
        logic              load_out;
        logic [IDX_W-1:0]  word_idx;
        logic              full;
        logic              last;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- rtl/sfcp_ifs.sv -----
`default_nettype none

interface sfcp_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface sfcp_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  word_index;
    logic [15:0] word_value;
    logic        start1_ok;
    logic        start2_ok;
    logic        length_ok;
    logic        checksum_ok;
    logic        frame_valid;
    logic        last;

    modport source (
        output valid, output word_index, output word_value, output start1_ok,
        output start2_ok, output length_ok, output checksum_ok, output frame_valid,
        output last, input ready
    );
    modport sink (
        input valid, input word_index, input word_value, input start1_ok,
        input start2_ok, input length_ok, input checksum_ok, input frame_valid,
        input last, output ready
    );
endinterface

`default_nettype wire

// ----- rtl/sfcp_ctrl.sv -----
`default_nettype none

module sfcp_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_command,
    input  wire logic [7:0]          i_rx_byte,
    input  sfcp_pkg::t_dp_status     i_status,
    output logic                     o_in_ready,
    output sfcp_pkg::t_dp_cmd        o_cmd
);
    import sfcp_pkg::*;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_full, n_full;
    logic              in_acc;
    logic              is_word_last;

    assign in_acc       = i_in_valid && o_in_ready;
    assign is_word_last = (r_cnt[IDX_W-1:0] == IDX_W'(WORD_COUNT - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SEEK;
            r_cnt   <= '0;
            r_full  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_full  <= n_full;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_SEEK: begin
                if (in_acc && i_command == CMD_BYTE && i_rx_byte == START1)
                    n_state = ST_FILL;
            end
            ST_FILL: begin
                if (in_acc && (i_command == CMD_TIMEOUT ||
                               r_cnt == CNT_W'(FRAME_LEN - 1)))
                    n_state = ST_SUM;
            end
            ST_SUM: begin
                if (r_cnt == CNT_W'(FRAME_LEN))
                    n_state = ST_HI;
            end
            ST_HI:  n_state = ST_LO;
            ST_LO:  n_state = ST_OUT;
            ST_OUT: begin
                if (i_status.out_free)
                    n_state = is_word_last ? ST_SEEK : ST_HI;
            end
            default: n_state = ST_SEEK;
        endcase
    end

    // counter and length flag
    always_comb begin
        n_cnt  = r_cnt;
        n_full = r_full;
        case (r_state)
            ST_SEEK: begin
                if (in_acc && i_command == CMD_BYTE && i_rx_byte == START1)
                    n_cnt = CNT_W'(1);
            end
            ST_FILL: begin
                if (in_acc) begin
                    if (i_command == CMD_TIMEOUT) begin
                        n_cnt  = '0;
                        n_full = 1'b0;
                    end else if (r_cnt == CNT_W'(FRAME_LEN - 1)) begin
                        n_cnt  = '0;
                        n_full = 1'b1;
                    end else begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end
            end
            ST_SUM: begin
                n_cnt = (r_cnt == CNT_W'(FRAME_LEN)) ? '0 : r_cnt + CNT_W'(1);
            end
            ST_OUT: begin
                if (i_status.out_free && !is_word_last)
                    n_cnt = r_cnt + CNT_W'(1);
            end
            default: n_cnt = r_cnt;
        endcase
    end

    // outputs; ready is high in seek and fill, so valid alone marks a taken beat
    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        o_cmd.word_idx = r_cnt[IDX_W-1:0];
        o_cmd.full     = r_full;
        o_cmd.last     = is_word_last;
        case (r_state)
            ST_SEEK: begin
                o_in_ready    = 1'b1;
                o_cmd.wr_en   = i_in_valid && i_command == CMD_BYTE && i_rx_byte == START1;
                o_cmd.wr_addr = '0;
            end
            ST_FILL: begin
                o_in_ready    = 1'b1;
                o_cmd.wr_en   = i_in_valid && i_command == CMD_BYTE;
                o_cmd.wr_addr = r_cnt[ADDR_W-1:0];
            end
            ST_SUM: begin
                o_cmd.rd_en   = !r_cnt[CNT_W-1];
                o_cmd.rd_addr = r_cnt[ADDR_W-1:0];
                o_cmd.sum_clr = (r_cnt == '0);
                o_cmd.sum_acc = (r_cnt != '0);
            end
            ST_HI: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = {r_cnt[IDX_W-1:0], 1'b0} + WORD_BASE_ADDR;
            end
            ST_LO: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = {r_cnt[IDX_W-1:0], 1'b1} + WORD_BASE_ADDR;
                o_cmd.cap_hi  = 1'b1;
            end
            ST_OUT: begin
                o_cmd.load_out = i_status.out_free;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/sfcp_datapath.sv -----
`default_nettype none

module sfcp_datapath (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  sfcp_pkg::t_dp_cmd        i_cmd,
    input  wire logic [7:0]          i_rx_byte,
    input  wire logic                i_out_ready,
    output sfcp_pkg::t_dp_status     o_status,
    output logic                     o_out_valid,
    output logic [3:0]               o_word_index,
    output logic [15:0]              o_word_value,
    output logic                     o_start1_ok,
    output logic                     o_start2_ok,
    output logic                     o_length_ok,
    output logic                     o_checksum_ok,
    output logic                     o_frame_valid,
    output logic                     o_last
);
    import sfcp_pkg::*;

    logic [7:0]          r_mem [FRAME_LEN];
    logic [FRAME_LEN-1:0] r_vld;
    logic [7:0]          r_rd_data;
    logic [ADDR_W-1:0]   r_rd_addr;
    logic [SUM_W-1:0]    r_sum;
    logic                r_s1, r_s2;
    logic [7:0]          r_chk_hi, r_chk_lo;
    logic [7:0]          r_hi;
    logic                r_out_valid;
    logic [3:0]          r_word_index;
    logic [15:0]         r_word_value;
    logic                r_start1_ok, r_start2_ok, r_length_ok;
    logic                r_checksum_ok, r_frame_valid, r_last;
    logic                ck_ok;

    // frame buffer, unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en)
            r_mem[i_cmd.wr_addr] <= i_rx_byte;
        if (i_cmd.rd_en) begin
            r_rd_data <= r_vld[i_cmd.rd_addr] ? r_mem[i_cmd.rd_addr] : 8'h00;
            r_rd_addr <= i_cmd.rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_vld <= '0;
        else if (i_cmd.wr_en)
            r_vld[i_cmd.wr_addr] <= 1'b1;
    end

    // sweep: checksum and header bytes
    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_clr)
            r_sum <= '0;
        else if (i_cmd.sum_acc && r_rd_addr < ADDR_W'(SUM_LEN))
            r_sum <= r_sum + SUM_W'(r_rd_data);
        if (i_cmd.sum_acc) begin
            if (r_rd_addr == '0)
                r_s1 <= (r_rd_data == START1);
            if (r_rd_addr == ADDR_W'(1))
                r_s2 <= (r_rd_data == START2);
            if (r_rd_addr == CHK_HI_ADDR)
                r_chk_hi <= r_rd_data;
            if (r_rd_addr == CHK_LO_ADDR)
                r_chk_lo <= r_rd_data;
        end
        if (i_cmd.cap_hi)
            r_hi <= r_rd_data;
    end

    assign ck_ok = ({{(16 - SUM_W){1'b0}}, r_sum} == {r_chk_hi, r_chk_lo});

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (i_cmd.load_out)
            r_out_valid <= 1'b1;
        else if (i_out_ready)
            r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_word_index  <= i_cmd.word_idx;
            r_word_value  <= {r_hi, r_rd_data};
            r_start1_ok   <= r_s1;
            r_start2_ok   <= r_s2;
            r_length_ok   <= i_cmd.full;
            r_checksum_ok <= ck_ok;
            r_frame_valid <= r_s1 && r_s2 && i_cmd.full && ck_ok;
            r_last        <= i_cmd.last;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_word_index      = r_word_index;
    assign o_word_value      = r_word_value;
    assign o_start1_ok       = r_start1_ok;
    assign o_start2_ok       = r_start2_ok;
    assign o_length_ok       = r_length_ok;
    assign o_checksum_ok     = r_checksum_ok;
    assign o_frame_valid     = r_frame_valid;
    assign o_last            = r_last;

endmodule

`default_nettype wire

// ----- rtl/sensor_frame_checksum_parser.sv -----
// Channel  Dir  Beat contents                                   Handshake
// i_in     in   command, rx_byte                                valid/ready
// o_out    out  word_index, word_value, four check flags,       valid/ready
//               frame_valid, last
//
// Bytes and timeout ticks are taken one per cycle while a frame is seeked or filled.
// A frame end (32nd byte or timeout in frame) starts a sweep of the byte buffer for
// the checksum, then for each of 12 words two buffer reads and one load, the load
// waiting while o_out is not free.
// Synchronous active-low reset; buffer reads as zero until written, no clearing pass.
// o_out stalls hold the word sweep; input is taken again once the last word is loaded.
`default_nettype none

module sensor_frame_checksum_parser (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sfcp_in_if.sink     i_in,
    sfcp_out_if.source  o_out
);
    import sfcp_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic       in_ready;

    // controller: seek/fill tracking, buffer sweep and word sequencing
    sfcp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_command  (i_in.command),
        .i_rx_byte  (i_in.rx_byte),
        .i_status   (dp_status),
        .o_in_ready (in_ready),
        .o_cmd      (dp_cmd)
    );

    assign i_in.ready = in_ready;

    // datapath: byte buffer, checksum accumulator, output register
    sfcp_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_rx_byte     (i_in.rx_byte),
        .i_out_ready   (o_out.ready),
        .o_status      (dp_status),
        .o_out_valid   (o_out.valid),
        .o_word_index  (o_out.word_index),
        .o_word_value  (o_out.word_value),
        .o_start1_ok   (o_out.start1_ok),
        .o_start2_ok   (o_out.start2_ok),
        .o_length_ok   (o_out.length_ok),
        .o_checksum_ok (o_out.checksum_ok),
        .o_frame_valid (o_out.frame_valid),
        .o_last        (o_out.last)
    );

endmodule

`default_nettype wire

// ----- rtl/sfcp_checker.sv -----
`default_nettype none
`include "sensor_frame_checksum_parser_macros.svh"

module sfcp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [3:0]  i_word_index,
    input wire logic [15:0] i_word_value,
    input wire logic        i_start1_ok,
    input wire logic        i_start2_ok,
    input wire logic        i_length_ok,
    input wire logic        i_checksum_ok,
    input wire logic        i_frame_valid,
    input wire logic        i_last
);

    // a stalled beat keeps its word
    `SFCP_CHK_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_word_value) && $stable(i_word_index), "out beat changed under stall")

    // last marks word 11 and only that
    `SFCP_CHK_SAME(a_last_idx, i_out_valid, i_last == (i_word_index == 4'd11) && i_word_index <= 4'd11, "last/index mismatch")

    // frame_valid is the AND of the four checks
    `SFCP_CHK_SAME(a_valid_and, i_out_valid, i_frame_valid == (i_start1_ok && i_start2_ok && i_length_ok && i_checksum_ok), "frame_valid mismatch")

    // a new frame needs its own buffer sweep, so o_out goes idle after the last word
    `SFCP_CHK_NEXT(a_frame_gap, i_out_valid && i_out_ready && i_last, !i_out_valid, "out beat right after last word")

endmodule

bind sensor_frame_checksum_parser sfcp_checker u_sfcp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_word_index  (o_out.word_index),
    .i_word_value  (o_out.word_value),
    .i_start1_ok   (o_out.start1_ok),
    .i_start2_ok   (o_out.start2_ok),
    .i_length_ok   (o_out.length_ok),
    .i_checksum_ok (o_out.checksum_ok),
    .i_frame_valid (o_out.frame_valid),
    .i_last        (o_out.last)
);

`default_nettype wire
